// ===== hdl/ffha_pkg.sv =====
// Shared constants and codes for the first-fit heap allocator.
// No dependencies; every other file but ffha_ram imports this package.
package ffha_pkg;

   localparam int OFFSET_W = 16;
   localparam int BYTES_W  = 16;
   localparam int CSR_W    = 17;
   localparam int STATUS_W = 3;
   localparam int REQ_G_W  = 14;    // granules of a rounded request
   localparam int HEAP_MIN_G = 8;   // smallest heap in granules

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_BLOCK = 3'd4;

endpackage

// ===== hdl/ffha_req_if.sv =====
// Request channel of the heap allocator: valid/ready plus request beat.
// Depends on ffha_pkg.
interface ffha_req_if
   import ffha_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                func;
   logic [BYTES_W-1:0]  req_bytes;
   logic [OFFSET_W-1:0] data_offset;

   modport source (output valid, func, req_bytes, data_offset, input ready);
   modport sink   (input valid, func, req_bytes, data_offset, output ready);
endinterface

// ===== hdl/ffha_rsp_if.sv =====
// Response channel of the heap allocator: valid/ready plus result beat.
// Depends on ffha_pkg.
interface ffha_rsp_if
   import ffha_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] result_offset;
   logic [STATUS_W-1:0] status;

   modport source (output valid, result_offset, status, input ready);
   modport sink   (input valid, result_offset, status, output ready);
endinterface

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator. The heap is a chain of contiguous blocks, each
// described by a header entry (allocated bit and span in 8-byte granules)
// held in one RAM indexed by granule. An allocate walks the chain from
// granule 0 one header per cycle, takes the first free block that fits,
// and splits it when the remainder is large enough; a free walks the chain
// to the block whose data starts at the offset, reads its successor when
// one lies in the heap, then writes one merged header. Each item passes
// S_IDLE, the walk (S_WALK, one header visited per cycle through the
// single RAM read port), S_SPLIT or S_FNEXT when needed, and S_DONE.
// Zero-size, misaligned and outside-heap requests skip the walk. After
// reset or a heap_bytes write the block seeds header 0 in S_INIT and
// takes no request meanwhile. The response sits in an output register,
// so a finished beat never blocks the start of the next request.
// Depends on ffha_pkg, ffha_req_if, ffha_rsp_if and ffha_ram.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 24,
   parameter int MIN_SPLIT    = 32
) (
   input  logic             clock,
   input  logic             reset,
   ffha_req_if.sink         req_chan,
   ffha_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   localparam int DEPTH   = HEAP_BYTES / 8;
   localparam int AW      = $clog2(DEPTH);
   localparam int SPAN_W  = $clog2(DEPTH + 1);
   localparam int CW      = ((SPAN_W > REQ_G_W) ? SPAN_W : REQ_G_W) + 2;
   localparam int HG      = (HEADER_BYTES + 7) / 8;          // header granules
   localparam int MS_G    = (MIN_SPLIT + 7) / 8;
   localparam int SPLIT_G = (MS_G > HG + 1) ? MS_G : HG + 1;  // least remnant
   localparam int LIM_RST = (DEPTH < 8192) ? DEPTH : 8192;
   localparam int ENT_W   = SPAN_W + 1;

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_WALK  = 6'b000100,
      S_SPLIT = 6'b001000,
      S_FNEXT = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [SPAN_W-1:0]   lim_ff, lim_in;
   logic [SPAN_W-1:0]   g_ff, g_in;
   logic [SPAN_W-1:0]   s_ff, s_in;
   logic [SPAN_W-1:0]   prev_g_ff, prev_g_in;
   logic [SPAN_W-1:0]   prev_s_ff, prev_s_in;
   logic                prev_alloc_ff, prev_alloc_in;
   logic                has_prev_ff, has_prev_in;
   logic                func_ff, func_in;
   logic [CW-1:0]       need_ff, need_in;     // request granules
   logic [CW-1:0]       off_g_ff, off_g_in;   // free offset in granules
   logic [SPAN_W-1:0]   split_g_ff, split_g_in;
   logic [SPAN_W-1:0]   split_s_ff, split_s_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [AW-1:0]     rd_addr;
   logic [ENT_W-1:0]  rd_data;

   logic              rd_alloc;
   logic [SPAN_W-1:0] rd_span;
   logic [CW-1:0]     walk_next, need_tot, rem, g_ext, clamp_v;
   logic              fit, do_split, hit, next_in_heap, prev_free;
   logic [16:0]       rounded;
   logic [31:0]       data_pos;
   logic [SPAN_W-1:0] merge_s, next_add;

   ffha_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_alloc     = rd_data[SPAN_W];
   assign rd_span      = rd_data[SPAN_W-1:0];
   assign g_ext        = CW'(g_ff);
   assign walk_next    = g_ext + CW'(rd_span);
   assign need_tot     = CW'(HG) + need_ff;
   assign fit          = !rd_alloc && (CW'(rd_span) >= need_tot);
   assign rem          = CW'(rd_span) - need_tot;
   assign do_split     = rem >= CW'(SPLIT_G);
   assign hit          = (g_ext + CW'(HG)) == off_g_ff;
   assign next_in_heap = walk_next < CW'(lim_ff);
   assign prev_free    = has_prev_ff && !prev_alloc_ff;
   assign rounded      = (17'(req_chan.req_bytes) + 17'd7) & ~17'd7;
   assign data_pos     = 32'({g_ff, 3'b000}) + 32'(HG * 8);
   assign clamp_v      = CW'(csr_wdata[CSR_W-1:3]);

   // Successor's span is added only if it is a free block.
   assign next_add = (state_ff == S_FNEXT && rd_span != '0 && !rd_alloc) ?
                     rd_span : '0;
   assign merge_s  = ((state_ff == S_FNEXT) ? s_ff : rd_span) + next_add +
                     (prev_free ? prev_s_ff : '0);

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_offset = rsp_off_ff;
   assign rsp_chan.status        = rsp_st_ff;

   always_comb begin
      state_in      = state_ff;
      lim_in        = lim_ff;
      g_in          = g_ff;
      s_in          = s_ff;
      prev_g_in     = prev_g_ff;
      prev_s_in     = prev_s_ff;
      prev_alloc_in = prev_alloc_ff;
      has_prev_in   = has_prev_ff;
      func_in       = func_ff;
      need_in       = need_ff;
      off_g_in      = off_g_ff;
      split_g_in    = split_g_ff;
      split_s_in    = split_s_ff;
      res_off_in    = res_off_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_off_in    = rsp_off_ff;
      rsp_st_in     = rsp_st_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = walk_next[AW-1:0];

      case (state_ff)
         S_INIT: begin
            // seed one free block spanning the heap
            wr_en    = 1'b1;
            wr_data  = {1'b0, lim_ff};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            rd_addr     = '0;
            g_in        = '0;
            has_prev_in = 1'b0;
            func_in     = req_chan.func;
            need_in     = CW'(rounded[16:3]);
            off_g_in    = CW'(req_chan.data_offset[OFFSET_W-1:3]);
            res_off_in  = '0;
            if (req_chan.valid) begin
               state_in = S_WALK;
               if (req_chan.func == FUNC_ALLOC) begin
                  if (rounded == '0) begin
                     res_st_in = ST_NO_FIT;
                     state_in  = S_DONE;
                  end
               end else if (req_chan.data_offset[2:0] != '0) begin
                  res_st_in = ST_MISALIGN;
                  state_in  = S_DONE;
               end else if (CW'(req_chan.data_offset[OFFSET_W-1:3]) >=
                            CW'(lim_ff)) begin
                  res_st_in = ST_OUTSIDE;
                  state_in  = S_DONE;
               end
            end
         end
         S_WALK: begin
            s_in = rd_span;
            if (rd_span == '0) begin
               res_st_in = (func_ff == FUNC_ALLOC) ? ST_NO_FIT : ST_NOT_BLOCK;
               state_in  = S_DONE;
            end else if (func_ff == FUNC_ALLOC) begin
               if (fit) begin
                  wr_en      = 1'b1;
                  wr_addr    = g_ff[AW-1:0];
                  wr_data    = {1'b1, do_split ? SPAN_W'(need_tot) : rd_span};
                  split_g_in = SPAN_W'(g_ext + need_tot);
                  split_s_in = SPAN_W'(rem);
                  res_off_in = data_pos[OFFSET_W-1:0];
                  res_st_in  = ST_OK;
                  state_in   = do_split ? S_SPLIT : S_DONE;
               end else if (next_in_heap) begin
                  g_in = SPAN_W'(walk_next);
               end else begin
                  res_st_in = ST_NO_FIT;
                  state_in  = S_DONE;
               end
            end else begin
               if (hit) begin
                  res_st_in = ST_OK;
                  if (next_in_heap) begin
                     state_in = S_FNEXT;   // successor header being read
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = prev_free ? prev_g_ff[AW-1:0] : g_ff[AW-1:0];
                     wr_data  = {1'b0, merge_s};
                     state_in = S_DONE;
                  end
               end else if (next_in_heap) begin
                  prev_g_in     = g_ff;
                  prev_s_in     = rd_span;
                  prev_alloc_in = rd_alloc;
                  has_prev_in   = 1'b1;
                  g_in          = SPAN_W'(walk_next);
               end else begin
                  res_st_in = ST_NOT_BLOCK;
                  state_in  = S_DONE;
               end
            end
         end
         S_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = split_g_ff[AW-1:0];
            wr_data  = {1'b0, split_s_ff};
            state_in = S_DONE;
         end
         S_FNEXT: begin
            wr_en    = 1'b1;
            wr_addr  = prev_free ? prev_g_ff[AW-1:0] : g_ff[AW-1:0];
            wr_data  = {1'b0, merge_s};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (csr_we) begin
         if (clamp_v > CW'(DEPTH)) begin
            lim_in = SPAN_W'(DEPTH);
         end else if (clamp_v < CW'(HEAP_MIN_G)) begin
            lim_in = SPAN_W'(HEAP_MIN_G);
         end else begin
            lim_in = SPAN_W'(clamp_v);
         end
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         lim_ff       <= SPAN_W'(LIM_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff          <= g_in;
      s_ff          <= s_in;
      prev_g_ff     <= prev_g_in;
      prev_s_ff     <= prev_s_in;
      prev_alloc_ff <= prev_alloc_in;
      has_prev_ff   <= has_prev_in;
      func_ff       <= func_in;
      need_ff       <= need_in;
      off_g_ff      <= off_g_in;
      split_g_ff    <= split_g_in;
      split_s_ff    <= split_s_in;
      res_off_ff    <= res_off_in;
      res_st_ff     <= res_st_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_st_ff     <= rsp_st_in;
   end

   // A heap size write always reseeds the header store next cycle.
   a_csr_reseed: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> state_ff == S_INIT)
      else $error("heap size write did not reseed header store");

   // Walk never visits a granule outside the heap.
   a_walk_in_heap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> g_ff < lim_ff)
      else $error("walk left the heap");

   // Failures and frees carry a zero offset; granted offsets are aligned.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff != ST_OK |-> rsp_off_ff == '0)
      else $error("failed response with non-zero offset");

   a_ok_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_off_ff[2:0] == 3'b000)
      else $error("misaligned response offset");

endmodule

// ===== hdl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
